>>> hdl/cycle_aligned_schedule_times_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cycle-aligned schedule time block
// Shared property templates; each use stands on a line of its own.
// ---------------------------------------------------------------------------
`ifndef CYCLE_ALIGNED_SCHEDULE_TIMES_ASSERT_SVH
`define CYCLE_ALIGNED_SCHEDULE_TIMES_ASSERT_SVH

// a implies b in the same cycle
`define CAST_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// a implies b at the delay set by argument n
`define CAST_ASSERT_DELAY(label, clk, rst, a, n, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("latency check failed");

`endif

>>> hdl/cast_pkg.sv
// ---------------------------------------------------------------------------
// cast_pkg
// Types, constants and time normalization helpers for the schedule block.
// ---------------------------------------------------------------------------
package cast_pkg;

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam int          ELAPSED_W = 62;
  localparam int          SUB_BIAS  = 9;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BASE_SEC  = 3'd0;
  localparam logic [2:0] REG_BASE_NS   = 3'd1;
  localparam logic [2:0] REG_INTERVAL  = 3'd2;
  localparam logic [2:0] REG_SEND_OFS  = 3'd3;
  localparam logic [2:0] REG_SEND_APP  = 3'd4;
  localparam logic [2:0] REG_JITTER    = 3'd5;
  localparam logic [2:0] REG_RECV_OFS  = 3'd6;
  localparam logic [2:0] REG_RECV_APP  = 3'd7;

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] ns;
  } stime_t;

  // request state as it moves through the remainder chain
  typedef struct packed {
    logic                 lt;
    stime_t               now;
    logic [ELAPSED_W-1:0] elapsed;
    logic [31:0]          rem;
  } cell_t;

  // fold a nanosecond total (< 11 s) into seconds, minus the given bias
  function automatic stime_t norm_time(logic [31:0] sec, logic [34:0] total,
                                       logic [3:0] bias);
    logic [3:0] q;
    stime_t     r;
    q = '0;
    for (int k = 1; k <= 10; k++) begin
      if (total >= 35'(k) * 35'(NS_PER_S)) q = q + 4'd1;
    end
    r.ns  = 30'(total - 35'(q) * 35'(NS_PER_S));
    r.sec = sec + 32'(q) - 32'(bias);
    return r;
  endfunction

  function automatic stime_t add_ns(stime_t t, logic [33:0] d);
    return norm_time(t.sec, 35'(t.ns) + 35'(d), 4'd0);
  endfunction

  // bias keeps the sum positive; d stays below 2^33
  function automatic stime_t sub_ns(stime_t t, logic [33:0] d);
    return norm_time(t.sec,
                     35'(t.ns) + 35'(SUB_BIAS) * 35'(NS_PER_S) - 35'(d),
                     4'(SUB_BIAS));
  endfunction

  // bring a nanoseconds field of up to 2^30-1 below one second
  function automatic stime_t norm_in(logic [31:0] sec, logic [29:0] ns);
    return norm_time(sec, 35'(ns), 4'd0);
  endfunction

endpackage

>>> hdl/cast_div_cell.sv
// ---------------------------------------------------------------------------
// cast_div_cell
// One remainder step: takes the top elapsed bit into the partial remainder.
// ---------------------------------------------------------------------------
module cast_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  cast_pkg::cell_t in_data,
  input  logic [31:0]     step,
  output logic            out_valid,
  output cast_pkg::cell_t out_data
);
  import cast_pkg::*;

  logic [32:0] trial;
  logic [33:0] diff;
  cell_t       data_next;

  // restoring remainder step
  always_comb begin
    trial = {in_data.rem, in_data.elapsed[ELAPSED_W-1]};
    diff  = {1'b0, trial} - {2'b00, step};
    data_next         = in_data;
    data_next.elapsed = {in_data.elapsed[ELAPSED_W-2:0], 1'b0};
    data_next.rem     = diff[33] ? trial[31:0] : diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

>>> hdl/cycle_aligned_schedule_times.sv
// ---------------------------------------------------------------------------
// cycle_aligned_schedule_times
// Next cycle start and derived transmit and wakeup times from a base time.
// ---------------------------------------------------------------------------
// One request per clock, busy never rises. Each result appears on done after its
// request has passed 3 front stages, one cell per elapsed bit in the 62-cell
// remainder chain, and 4 time adjust stages; the receiver cannot stall, so a
// result is shown for one cycle only. Registers may be written only while no
// request is in flight.
module cycle_aligned_schedule_times #(
  parameter int SEND_STACK_DELAY    = 0,
  parameter int RECEIVE_STACK_DELAY = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] now_seconds,
  input  logic [29:0] now_nanoseconds,
  output logic        done,
  output logic [31:0] start_seconds,
  output logic [29:0] start_nanoseconds,
  output logic [31:0] transmit_seconds,
  output logic [29:0] transmit_nanoseconds,
  output logic [31:0] send_wake_seconds,
  output logic [29:0] send_wake_nanoseconds,
  output logic [31:0] receive_wake_seconds,
  output logic [29:0] receive_wake_nanoseconds
);
  import cast_pkg::*;
  `include "cycle_aligned_schedule_times_assert.svh"

  localparam int LATENCY = 3 + ELAPSED_W + 4;

  // configuration registers
  logic [31:0] base_seconds;
  logic [29:0] base_nanoseconds;
  logic [31:0] cycle_interval;
  logic [31:0] send_offset;
  logic [30:0] send_app_delay;
  logic [30:0] wakeup_jitter;
  logic [29:0] receive_offset;
  logic [31:0] receive_app_delay;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seconds      <= '0;
      base_nanoseconds  <= '0;
      cycle_interval    <= 32'd1000000;
      send_offset       <= '0;
      send_app_delay    <= '0;
      wakeup_jitter     <= '0;
      receive_offset    <= '0;
      receive_app_delay <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_BASE_SEC: base_seconds      <= pwdata;
        REG_BASE_NS:  base_nanoseconds  <= pwdata[29:0];
        REG_INTERVAL: cycle_interval    <= pwdata;
        REG_SEND_OFS: send_offset       <= pwdata;
        REG_SEND_APP: send_app_delay    <= pwdata[30:0];
        REG_JITTER:   wakeup_jitter     <= pwdata[30:0];
        REG_RECV_OFS: receive_offset    <= pwdata[29:0];
        REG_RECV_APP: receive_app_delay <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BASE_SEC: prdata = base_seconds;
      REG_BASE_NS:  prdata = 32'(base_nanoseconds);
      REG_INTERVAL: prdata = cycle_interval;
      REG_SEND_OFS: prdata = send_offset;
      REG_SEND_APP: prdata = 32'(send_app_delay);
      REG_JITTER:   prdata = 32'(wakeup_jitter);
      REG_RECV_OFS: prdata = 32'(receive_offset);
      REG_RECV_APP: prdata = receive_app_delay;
      default:      prdata = '0;
    endcase
  end

  // zero interval acts as one ns
  logic [31:0] step;
  assign step = (cycle_interval == '0) ? 32'd1 : cycle_interval;

  // stage A: normalize, compare against base, split difference
  logic        in_acc;
  logic [32:0] now_sec33, base_sec33, dsec_c;
  logic [29:0] now_ns_n, base_ns_n;
  logic        lt_c;
  stime_t      base_n;

  assign in_acc = start & ~busy;

  always_comb begin
    now_sec33  = {1'b0, now_seconds};
    now_ns_n   = now_nanoseconds;
    if (now_nanoseconds >= NS_PER_S) begin
      now_sec33 = now_sec33 + 33'd1;
      now_ns_n  = now_nanoseconds - NS_PER_S;
    end
    base_sec33 = {1'b0, base_seconds};
    base_ns_n  = base_nanoseconds;
    if (base_nanoseconds >= NS_PER_S) begin
      base_sec33 = base_sec33 + 33'd1;
      base_ns_n  = base_nanoseconds - NS_PER_S;
    end
    lt_c   = (now_sec33 < base_sec33) ||
             ((now_sec33 == base_sec33) && (now_ns_n < base_ns_n));
    dsec_c = lt_c ? '0 : (now_sec33 - base_sec33);
    base_n.sec = base_sec33[31:0];
    base_n.ns  = base_ns_n;
  end

  logic        a_valid, b_valid, c_valid;
  logic        a_lt, b_lt, c_lt;
  stime_t      a_now, b_now, c_now;
  logic [32:0] a_dsec;
  logic [30:0] a_dns, b_dns;
  logic [62:0] b_prod;
  logic [ELAPSED_W-1:0] c_elapsed;
  logic [63:0] sum_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= in_acc;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // stage B multiplies whole seconds, stage C adds the signed ns part
  assign sum_c = 64'(b_prod) + {{33{b_dns[30]}}, b_dns};

  always_ff @(posedge clk) begin
    a_lt      <= lt_c;
    a_now.sec <= now_sec33[31:0];
    a_now.ns  <= now_ns_n;
    a_dsec    <= dsec_c;
    a_dns     <= lt_c ? '0 : (31'(now_ns_n) - 31'(base_ns_n));
    b_lt      <= a_lt;
    b_now     <= a_now;
    b_prod    <= 63'(a_dsec) * 63'(NS_PER_S);
    b_dns     <= a_dns;
    c_lt      <= b_lt;
    c_now     <= b_now;
    c_elapsed <= sum_c[ELAPSED_W-1:0];
  end

  // remainder chain, one cell per elapsed bit
  logic  chain_valid [ELAPSED_W+1];
  cell_t chain_data  [ELAPSED_W+1];

  assign chain_valid[0] = c_valid;
  assign chain_data[0]  = {c_lt, c_now, c_elapsed, 32'd0};

  for (genvar g = 0; g < ELAPSED_W; g++) begin : g_cell
    cast_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .step      (step),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  // time adjust stages
  cell_t       cf;
  logic [33:0] recv_add, send_sub;
  logic        f1_valid, f2_valid, f3_valid, f4_valid;
  stime_t      f1_start, f2_start, f3_start, f4_start;
  stime_t      f2_tx, f2_rw, f3_tx, f3_rw, f4_tx, f4_sw, f4_rw;

  assign cf       = chain_data[ELAPSED_W];
  assign recv_add = 34'(receive_offset) + 34'(RECEIVE_STACK_DELAY) + 34'(wakeup_jitter);
  assign send_sub = 34'(send_app_delay) + 34'(wakeup_jitter);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
    end else begin
      f1_valid <= chain_valid[ELAPSED_W];
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_start <= cf.lt ? base_n
                      : add_ns(cf.now, 34'({1'b0, step} - {1'b0, cf.rem}));
    f2_start <= f1_start;
    f2_tx    <= add_ns(f1_start, 34'(send_offset));
    f2_rw    <= add_ns(f1_start, recv_add);
    f3_start <= f2_start;
    f3_tx    <= sub_ns(f2_tx, 34'(SEND_STACK_DELAY));
    f3_rw    <= sub_ns(f2_rw, 34'(receive_app_delay));
    f4_start <= f3_start;
    f4_tx    <= f3_tx;
    f4_sw    <= sub_ns(f3_tx, send_sub);
    f4_rw    <= f3_rw;
  end

  assign done                     = f4_valid;
  assign start_seconds            = f4_start.sec;
  assign start_nanoseconds        = f4_start.ns;
  assign transmit_seconds         = f4_tx.sec;
  assign transmit_nanoseconds     = f4_tx.ns;
  assign send_wake_seconds        = f4_sw.sec;
  assign send_wake_nanoseconds    = f4_sw.ns;
  assign receive_wake_seconds     = f4_rw.sec;
  assign receive_wake_nanoseconds = f4_rw.ns;

  // checks
  logic ns_ok;
  assign ns_ok = (start_nanoseconds < NS_PER_S) && (send_wake_nanoseconds < NS_PER_S) &&
                 (receive_wake_nanoseconds < NS_PER_S);

  `CAST_ASSERT_DELAY(a_latency, clk, rst, in_acc, LATENCY, done)
  `CAST_ASSERT_IMPL(a_ns_range, clk, rst, done, ns_ok)
  `CAST_ASSERT_IMPL(a_rem_range, clk, rst, chain_valid[ELAPSED_W], cf.rem < step)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for cycle_aligned_schedule_times
// Drives time requests through the command port and register settings over
// the APB port, predicts the next cycle start and the derived transmit and
// wakeup times, and compares each result strobe with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  import cast_pkg::*;

  localparam longint unsigned NSEC  = 64'd1000000000;
  localparam longint unsigned WRAP  = 64'd4294967296 * NSEC;
  localparam int              LAT   = 69;
  localparam int              LIMIT = 4000;

  typedef struct {
    logic [31:0] sec;
    logic [29:0] ns;
  } req_t;

  typedef struct {
    logic [31:0] s_sec;
    logic [29:0] s_ns;
    logic [31:0] t_sec;
    logic [29:0] t_ns;
    logic [31:0] sw_sec;
    logic [29:0] sw_ns;
    logic [31:0] rw_sec;
    logic [29:0] rw_ns;
  } sched_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        start, busy, done;
  logic [31:0] now_seconds;
  logic [29:0] now_nanoseconds;
  logic [31:0] start_seconds, transmit_seconds, send_wake_seconds, receive_wake_seconds;
  logic [29:0] start_nanoseconds, transmit_nanoseconds;
  logic [29:0] send_wake_nanoseconds, receive_wake_nanoseconds;

  cycle_aligned_schedule_times u_dut (.*);

  // shadow copy of the schedule registers
  logic [31:0] sh_base_sec, sh_interval, sh_send_ofs, sh_recv_app;
  logic [29:0] sh_base_ns, sh_recv_ofs;
  logic [30:0] sh_send_app, sh_jitter;

  req_t   pending_reqs[$];
  sched_t expected_times[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     calm = 0;
  bit     hold = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned wrap_add(longint unsigned t, longint unsigned d);
    return (t + (d % WRAP)) % WRAP;
  endfunction

  function automatic longint unsigned wrap_sub(longint unsigned t, longint unsigned d);
    d = d % WRAP;
    return (t >= d) ? t - d : t + (WRAP - d);
  endfunction

  // next cycle start and derived times for one current time
  function automatic sched_t schedule_for(req_t r);
    longint unsigned now_t, base_t, per, st, tx, sw, rw;
    sched_t e;
    now_t  = longint'(r.sec) * NSEC + longint'(r.ns);
    base_t = longint'(sh_base_sec) * NSEC + longint'(sh_base_ns);
    per    = (sh_interval == 0) ? 64'd1 : longint'(sh_interval);
    if (now_t < base_t) st = base_t % WRAP;
    else st = (base_t + ((now_t - base_t) / per + 1) * per) % WRAP;
    tx = wrap_add(st, longint'(sh_send_ofs));
    sw = wrap_sub(tx, longint'(sh_send_app) + longint'(sh_jitter));
    rw = wrap_add(st, longint'(sh_recv_ofs) + longint'(sh_jitter));
    rw = wrap_sub(rw, longint'(sh_recv_app));
    e.s_sec  = 32'(st / NSEC);  e.s_ns  = 30'(st % NSEC);
    e.t_sec  = 32'(tx / NSEC);  e.t_ns  = 30'(tx % NSEC);
    e.sw_sec = 32'(sw / NSEC);  e.sw_ns = 30'(sw % NSEC);
    e.rw_sec = 32'(rw / NSEC);  e.rw_ns = 30'(rw % NSEC);
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    errors++;
  endtask

  // driver: one request per accepted start
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_times.push_back(schedule_for('{now_seconds, now_nanoseconds}));
      if ((start && !busy) || !start) begin
        if (!hold && pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
          req_t r;
          r = pending_reqs.pop_front();
          start           <= 1'b1;
          now_seconds     <= r.sec;
          now_nanoseconds <= r.ns;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_times.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        sched_t e;
        e = expected_times.pop_front();
        if (start_seconds !== e.s_sec) report_mismatch("start_seconds", start_seconds, e.s_sec);
        if (start_nanoseconds !== e.s_ns)
          report_mismatch("start_nanoseconds", 32'(start_nanoseconds), 32'(e.s_ns));
        if (transmit_seconds !== e.t_sec)
          report_mismatch("transmit_seconds", transmit_seconds, e.t_sec);
        if (transmit_nanoseconds !== e.t_ns)
          report_mismatch("transmit_nanoseconds", 32'(transmit_nanoseconds), 32'(e.t_ns));
        if (send_wake_seconds !== e.sw_sec)
          report_mismatch("send_wake_seconds", send_wake_seconds, e.sw_sec);
        if (send_wake_nanoseconds !== e.sw_ns)
          report_mismatch("send_wake_nanoseconds", 32'(send_wake_nanoseconds), 32'(e.sw_ns));
        if (receive_wake_seconds !== e.rw_sec)
          report_mismatch("receive_wake_seconds", receive_wake_seconds, e.rw_sec);
        if (receive_wake_nanoseconds !== e.rw_ns)
          report_mismatch("receive_wake_nanoseconds", 32'(receive_wake_nanoseconds),
                          32'(e.rw_ns));
      end
    end
  end

  // watchdog on cycles with no request, result or register access
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // register write over APB: setup then access
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BASE_SEC: sh_base_sec = val;
      REG_BASE_NS:  sh_base_ns  = val[29:0];
      REG_INTERVAL: sh_interval = val;
      REG_SEND_OFS: sh_send_ofs = val;
      REG_SEND_APP: sh_send_app = val[30:0];
      REG_JITTER:   sh_jitter   = val[30:0];
      REG_RECV_OFS: sh_recv_ofs = val[29:0];
      REG_RECV_APP: sh_recv_app = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    @(posedge clk);
    while (start || expected_times.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [29:0] rand_ns();
    case ($urandom_range(4))
      0: return 30'($urandom_range(999999999, 999999990));
      1: return 30'($urandom_range(32'h3FFFFFFF, 1000000000));
      2: return 30'($urandom_range(9));
      default: return 30'($urandom_range(999999999));
    endcase
  endfunction

  // mostly times near the base so the cycle count stays meaningful
  task automatic queue_random(int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: r.sec = $urandom;
        1: r.sec = sh_base_sec - 32'($urandom_range(1));
        default: r.sec = sh_base_sec + 32'($urandom_range(3));
      endcase
      r.ns = rand_ns();
      pending_reqs.push_back(r);
    end
  endtask

  task automatic apply_settings(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  initial begin
    logic [31:0] cfg[8];
    rst = 1'b1; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; now_seconds = '0; now_nanoseconds = '0;
    sh_base_sec = 0; sh_base_ns = 0; sh_interval = 32'd1000000; sh_send_ofs = 0;
    sh_send_app = 0; sh_jitter = 0; sh_recv_ofs = 0; sh_recv_app = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then a base with extremes
    pending_reqs.push_back('{32'd0, 30'd0});
    pending_reqs.push_back('{32'hFFFFFFFF, 30'd999999999});
    pending_reqs.push_back('{32'hFFFFFFFF, 30'h3FFFFFFF});
    pending_reqs.push_back('{32'd5, 30'd1000000000});
    drain();
    cfg = '{32'd100, 32'd500, 32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h3FFFFFFF, 32'hFFFFFFFF};
    apply_settings(cfg);
    // before, equal to, and past the base; zero interval acts as one ns
    pending_reqs.push_back('{32'd100, 30'd499});
    pending_reqs.push_back('{32'd100, 30'd500});
    pending_reqs.push_back('{32'd100, 30'd501});
    pending_reqs.push_back('{32'd99, 30'h3FFFFFFF});
    pending_reqs.push_back('{32'd0, 30'd0});
    drain();
    // base nanoseconds past one second, maximal interval, wrap of seconds
    cfg = '{32'hFFFFFFFF, 32'h3FFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0,
            32'd0};
    apply_settings(cfg);
    pending_reqs.push_back('{32'hFFFFFFFF, 30'h3FFFFFFF});
    pending_reqs.push_back('{32'hFFFFFFFF, 30'd0});
    pending_reqs.push_back('{32'd0, 30'd0});
    pending_reqs.push_back('{32'hFFFFFFFE, 30'd999999999});
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg[0] = (ph == 5) ? 32'hFFFFFFFF : $urandom;
      cfg[1] = 32'(rand_ns());
      case ($urandom_range(3))
        0: cfg[2] = $urandom_range(3);
        1: cfg[2] = $urandom;
        default: cfg[2] = $urandom_range(2000000000);
      endcase
      cfg[3] = $urandom;
      cfg[4] = $urandom & 32'h7FFFFFFF;
      cfg[5] = $urandom & 32'h7FFFFFFF;
      cfg[6] = $urandom & 32'h3FFFFFFF;
      cfg[7] = $urandom;
      apply_settings(cfg);
      calm = (ph == 2);
      queue_random(50);
      // hold the sender until every prediction has arrived
      wait (pending_reqs.size() == 0);
      hold = 1'b1;
      @(posedge clk);
      while (expected_times.size() != 0) @(posedge clk);
      hold = 1'b0;
      queue_random(50);
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
